/* rtl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared constants and codes for the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // default depth of the transfer data store
    localparam int BUF_DEPTH_DEF = 32;

    // address byte bit 0 selects a read transaction
    localparam logic [7:0] READ_BIT = 8'h01;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_EVENT = 2'd1,
        K_WRITE = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_LOAD   = 3'd2,
        CMD_RECV   = 3'd3,
        CMD_ACKBIT = 3'd4,
        CMD_STOP   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BUSY      = 3'd1,
        ERR_COLLISION = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_ADDR_NACK = 3'd4,
        ERR_NO_BYTE   = 3'd5,
        ERR_DATA_NACK = 3'd6
    } t_err;

endpackage

/* rtl/i2cms_buf.sv */
// ----------------------------------------------------------------------------
// i2cms_buf
// Data byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2cms_buf #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF,
    parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/i2cms_ctrl.sv */
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transaction sequencer: latches an item, reads the data store, then steps
// the bus phase and writes back received or loaded bytes.
// ----------------------------------------------------------------------------
module i2cms_ctrl #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF,
    parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
    parameter int PW        = $clog2(BUF_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input channel
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_address_byte,
    input  logic [5:0]    i_transfer_length,
    input  logic          i_engine_busy,
    input  logic          i_ack_not_received,
    input  logic          i_buffer_full,
    input  logic          i_write_collision,
    input  logic          i_receive_overflow,
    input  logic [7:0]    i_rx_byte,
    input  logic [4:0]    i_buffer_index,
    input  logic [7:0]    i_buffer_value,
    // output channel
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_command,
    output logic [7:0]    o_tx_data,
    output logic          o_ack_bit,
    output logic          o_idle,
    output logic [2:0]    o_error_code,
    output logic [7:0]    o_read_data,
    // data store port
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_ADDR,
        PH_TX,
        PH_RX,
        PH_ACK,
        PH_STOP
    } t_phase;

    // bus sequence state
    t_phase        r_phase, n_phase;
    logic [7:0]    r_target, n_target;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_end, n_end;

    // latched item, one in flight
    logic          r_stage;
    i2cms_pkg::t_kind r_kind;
    logic [7:0]    r_addr;
    logic [5:0]    r_len;
    logic          r_ebusy, r_nack, r_full, r_wcol, r_ovf;
    logic [7:0]    r_rx;
    logic [4:0]    r_idx;
    logic [7:0]    r_val;
    logic          r_idx_ok;

    // result register
    logic          r_out_valid;
    logic [2:0]    r_command;
    logic [7:0]    r_tx_data;
    logic          r_ack_bit;
    logic          r_idle;
    logic [2:0]    r_error_code;
    logic [7:0]    r_read_data;

    i2cms_pkg::t_cmd n_cmd;
    i2cms_pkg::t_err n_err;
    logic [7:0]    n_txd, n_rd;
    logic          n_ackb;
    logic [PW-1:0] pos_inc, len_sat;
    logic          pos_done, inc_done, idx_ok, exec, accept;

    // one item at a time; the next is taken the cycle after the write-back,
    // so a read never overlaps a pending write to the same entry
    assign o_in_ready = !r_stage;
    assign accept     = i_in_valid && o_in_ready;
    assign exec       = r_stage && (!r_out_valid || i_out_ready);

    assign idx_ok = 32'(i_buffer_index) < BUF_DEPTH;

    // read on accept: buffer index for a read item, byte position otherwise
    assign o_rd_en   = accept;
    assign o_rd_addr = (i2cms_pkg::t_kind'(i_kind) == i2cms_pkg::K_READ) ?
                       AW'(i_buffer_index) : AW'(r_pos);

    assign pos_inc  = r_pos + PW'(1);
    assign pos_done = r_pos >= r_end;
    assign inc_done = pos_inc >= r_end;

    always_comb begin
        if (r_len == 6'd0) begin
            len_sat = PW'(1);
        end else if (32'(r_len) > BUF_DEPTH) begin
            len_sat = PW'(BUF_DEPTH);
        end else begin
            len_sat = PW'(r_len);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_target  = r_target;
        n_pos     = r_pos;
        n_end     = r_end;
        n_cmd     = i2cms_pkg::CMD_NONE;
        n_err     = i2cms_pkg::ERR_NONE;
        n_txd     = 8'd0;
        n_rd      = 8'd0;
        n_ackb    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_idx);
        o_wr_data = r_val;
        unique case (r_kind)
            i2cms_pkg::K_START: begin
                if (r_ebusy || r_phase != PH_IDLE) begin
                    n_err   = i2cms_pkg::ERR_BUSY;
                    n_phase = PH_IDLE;
                end else begin
                    n_target = r_addr;
                    n_pos    = '0;
                    n_end    = len_sat;
                    n_cmd    = i2cms_pkg::CMD_START;
                    n_phase  = PH_START;
                end
            end
            i2cms_pkg::K_EVENT: begin
                priority if (r_phase == PH_IDLE) begin
                    n_phase = PH_IDLE;
                end else if (r_wcol) begin
                    n_err   = i2cms_pkg::ERR_COLLISION;
                    n_phase = PH_IDLE;
                end else if (r_ovf) begin
                    n_err   = i2cms_pkg::ERR_OVERFLOW;
                    n_phase = PH_IDLE;
                end else begin
                    unique case (r_phase)
                        PH_START: begin
                            n_cmd   = i2cms_pkg::CMD_LOAD;
                            n_txd   = r_target;
                            n_phase = PH_ADDR;
                        end
                        PH_ADDR: begin
                            priority if (r_nack) begin
                                n_err   = i2cms_pkg::ERR_ADDR_NACK;
                                n_phase = PH_IDLE;
                            end else if ((r_target & i2cms_pkg::READ_BIT) != 8'd0) begin
                                n_cmd   = i2cms_pkg::CMD_RECV;
                                n_phase = PH_RX;
                            end else begin
                                n_cmd   = i2cms_pkg::CMD_LOAD;
                                n_txd   = i_rd_data;
                                n_pos   = pos_inc;
                                n_phase = PH_TX;
                            end
                        end
                        PH_RX: begin
                            if (!r_full) begin
                                n_err   = i2cms_pkg::ERR_NO_BYTE;
                                n_phase = PH_IDLE;
                            end else begin
                                o_wr_en   = exec;
                                o_wr_addr = AW'(r_pos);
                                o_wr_data = r_rx;
                                n_pos     = pos_inc;
                                n_ackb    = inc_done;
                                n_cmd     = i2cms_pkg::CMD_ACKBIT;
                                n_phase   = PH_ACK;
                            end
                        end
                        PH_TX: begin
                            priority if (r_nack) begin
                                n_err   = i2cms_pkg::ERR_DATA_NACK;
                                n_phase = PH_IDLE;
                            end else if (pos_done) begin
                                n_cmd   = i2cms_pkg::CMD_STOP;
                                n_phase = PH_STOP;
                            end else begin
                                n_cmd = i2cms_pkg::CMD_LOAD;
                                n_txd = i_rd_data;
                                n_pos = pos_inc;
                            end
                        end
                        PH_ACK: begin
                            if (pos_done) begin
                                n_cmd   = i2cms_pkg::CMD_STOP;
                                n_phase = PH_STOP;
                            end else begin
                                n_cmd   = i2cms_pkg::CMD_RECV;
                                n_phase = PH_RX;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            i2cms_pkg::K_WRITE: begin
                o_wr_en = exec && r_idx_ok;
            end
            i2cms_pkg::K_READ: begin
                n_rd = r_idx_ok ? i_rd_data : 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_target    <= '0;
            r_pos       <= '0;
            r_end       <= '0;
        end else begin
            if (accept) begin
                r_stage <= 1'b1;
            end else if (exec) begin
                r_stage <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (exec) begin
                r_phase  <= n_phase;
                r_target <= n_target;
                r_pos    <= n_pos;
                r_end    <= n_end;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i2cms_pkg::t_kind'(i_kind);
            r_addr   <= i_address_byte;
            r_len    <= i_transfer_length;
            r_ebusy  <= i_engine_busy;
            r_nack   <= i_ack_not_received;
            r_full   <= i_buffer_full;
            r_wcol   <= i_write_collision;
            r_ovf    <= i_receive_overflow;
            r_rx     <= i_rx_byte;
            r_idx    <= i_buffer_index;
            r_val    <= i_buffer_value;
            r_idx_ok <= idx_ok;
        end
        if (exec) begin
            r_command    <= n_cmd;
            r_tx_data    <= n_txd;
            r_ack_bit    <= n_ackb;
            r_idle       <= (n_phase == PH_IDLE);
            r_error_code <= n_err;
            r_read_data  <= n_rd;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_command    = r_command;
    assign o_tx_data    = r_tx_data;
    assign o_ack_bit    = r_ack_bit;
    assign o_idle       = r_idle;
    assign o_error_code = r_error_code;
    assign o_read_data  = r_read_data;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_end)
        else $error("byte position passed end position");

    a_wr_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> exec)
        else $error("store written outside the execute step");

    a_err_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != i2cms_pkg::ERR_NONE |-> o_idle)
        else $error("error reported without returning to idle");

    a_ack_with_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack_bit |-> o_command == i2cms_pkg::CMD_ACKBIT)
        else $error("ack bit set without ack command");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command == i2cms_pkg::CMD_START |-> !o_idle)
        else $error("start issued while reported idle");

endmodule

/* rtl/i2c_master_transaction_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Steps a 7-bit-address I2C master transaction over a byte-level bus engine.
// ----------------------------------------------------------------------------
// Each item passes through two steps: the first latches it and reads the
// data store (one read port, registered data); the second, which waits while
// the previous result is not taken, steps the bus phase, writes back a
// received or buffered byte and loads the result register. A new item is
// taken the cycle after the second step, never earlier, even while the
// previous result still waits to be taken. Every item gives exactly one
// result. Errors are reported in error_code and return the block to idle;
// a start with a length of zero runs one byte, and a length above the store
// depth is cut to the depth. Store entries never written read back undefined.
module i2c_master_transaction_sequencer #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_address_byte,
    input  logic [5:0] i_transfer_length,
    input  logic       i_engine_busy,
    input  logic       i_ack_not_received,
    input  logic       i_buffer_full,
    input  logic       i_write_collision,
    input  logic       i_receive_overflow,
    input  logic [7:0] i_rx_byte,
    input  logic [4:0] i_buffer_index,
    input  logic [7:0] i_buffer_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_command,
    output logic [7:0] o_tx_data,
    output logic       o_ack_bit,
    output logic       o_idle,
    output logic [2:0] o_error_code,
    output logic [7:0] o_read_data
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PW = $clog2(BUF_DEPTH + 1);

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    i2cms_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW),
        .PW        (PW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_address_byte     (i_address_byte),
        .i_transfer_length  (i_transfer_length),
        .i_engine_busy      (i_engine_busy),
        .i_ack_not_received (i_ack_not_received),
        .i_buffer_full      (i_buffer_full),
        .i_write_collision  (i_write_collision),
        .i_receive_overflow (i_receive_overflow),
        .i_rx_byte          (i_rx_byte),
        .i_buffer_index     (i_buffer_index),
        .i_buffer_value     (i_buffer_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_command          (o_command),
        .o_tx_data          (o_tx_data),
        .o_ack_bit          (o_ack_bit),
        .o_idle             (o_idle),
        .o_error_code       (o_error_code),
        .o_read_data        (o_read_data),
        .o_wr_en            (wr_en),
        .o_wr_addr          (wr_addr),
        .o_wr_data          (wr_data),
        .o_rd_en            (rd_en),
        .o_rd_addr          (rd_addr),
        .i_rd_data          (rd_data)
    );

    i2cms_buf #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
